// ===== design/bcg_pkg.sv =====
// Package for the battery charge gauge: table, widths, codes and helpers.
// Used by every module of the gauge; depends on nothing.
`default_nettype none
package bcg_pkg;
  localparam int TablePoints = 11;
  localparam int TimeBits    = 32;
  localparam int MvBits      = 16;
  localparam int PctBits     = 7;
  localparam int IdxBits     = $clog2(TablePoints);

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [1:0] KIND_CHARGER = 2'd2;
  localparam logic [1:0] KIND_POLL    = 2'd3;

  localparam logic [1:0] MODE_DIS   = 2'd0;
  localparam logic [1:0] MODE_CHG   = 2'd1;
  localparam logic [1:0] MODE_ENTER = 2'd2;
  localparam logic [1:0] MODE_LEAVE = 2'd3;

  localparam logic CFG_SETTLE = 1'b0;
  localparam logic CFG_START  = 1'b1;

  typedef logic [MvBits-1:0] mv_t;
  typedef logic [PctBits-1:0] pct_t;

  function automatic mv_t lut_mv(input logic [IdxBits-1:0] i);
    unique case (i)
      4'd0: lut_mv = 16'd800;
      4'd1: lut_mv = 16'd1000;
      4'd2: lut_mv = 16'd2000;
      4'd3: lut_mv = 16'd3000;
      4'd4: lut_mv = 16'd4000;
      4'd5: lut_mv = 16'd5000;
      4'd6: lut_mv = 16'd6000;
      4'd7: lut_mv = 16'd7000;
      4'd8: lut_mv = 16'd8000;
      4'd9: lut_mv = 16'd9000;
      default: lut_mv = 16'd9500;
    endcase
  endfunction

  function automatic pct_t lut_pct(input logic [IdxBits-1:0] i);
    unique case (i)
      4'd0: lut_pct = 7'd0;
      4'd1: lut_pct = 7'd10;
      4'd2: lut_pct = 7'd20;
      4'd3: lut_pct = 7'd30;
      4'd4: lut_pct = 7'd40;
      4'd5: lut_pct = 7'd50;
      4'd6: lut_pct = 7'd60;
      4'd7: lut_pct = 7'd70;
      4'd8: lut_pct = 7'd80;
      4'd9: lut_pct = 7'd90;
      default: lut_pct = 7'd100;
    endcase
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== design/bcg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bcg_pkg for widths and the control struct.
`default_nettype none
module bcg_div import bcg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [MvBits+PctBits-1:0] num_i,
  input  wire logic [MvBits-1:0] den_i,
  output div_ctl_t               ctl_o,
  output logic [MvBits+PctBits-1:0] quo_o
);
  localparam int NB = MvBits + PctBits;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0]   quo_q, quo_d;
  logic [MvBits:0] rem_q, rem_d;
  logic [MvBits-1:0] den_q;
  logic [CB-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [MvBits:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[MvBits-1:0], quo_q[NB-1]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = CB'(NB); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CB'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// ===== design/battery_charge_gauge_top.sv =====
// Top level of the battery charge gauge: sequencer, state and output register.
// Depends on bcg_pkg and bcg_div.
`default_nettype none
// The gauge takes one transaction at a time on the input channel (in_valid_i,
// in_stall_o) and returns exactly one result transaction per input on the
// output channel (out_valid_o, out_stall_i). A tick advances a wrapping time
// counter, a sample stores the battery voltage, a charger transaction changes
// the charging mode, and a poll recomputes the displayed percentage; while the
// charger is being entered or left, only once the settle time has passed.
// Ticks, samples and charger changes go straight to the output register. A poll
// that needs the table takes a segment scan, one table point per cycle, and then
// a serial divide, one quotient bit per cycle, whose done flag is registered.
// The result sits in an output register; while the receiver stalls, the
// result holds and no new input is taken until the result leaves.
// Reset loads the register defaults (settle 60 ticks, start 100 percent),
// mode discharging and clears the time, voltage and charger state. The user
// must write configuration only while idle; the gauge does not enforce it.
// Writing the start register reloads the displayed percentage, clamped to 100.
module battery_charge_gauge_top import bcg_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   kind_i,
  input  wire logic [15:0]  sample_mv_i,
  input  wire logic         charger_on_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [6:0]        shown_percent_o,
  output logic [1:0]        gauge_mode_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_APPL = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [15:0] settle_q;
  logic [1:0] mode_q, mode_d;
  pct_t disp_q, disp_d, last_q, last_d, lvl_q, lvl_d;
  logic [TimeBits-1:0] tick_q, tick_d, chg_tick_q, chg_tick_d;
  mv_t bat_q, bat_d, chg_mv_q, chg_mv_d, off_q, off_d, v_q, v_d;
  logic flag_q, flag_d;
  logic [IdxBits-1:0] idx_q, idx_d;
  logic out_v_q, out_v_d;
  logic [6:0] op_q, op_d;
  logic [1:0] om_q, om_d;

  logic div_start;
  logic [MvBits+PctBits-1:0] div_num, div_quo;
  mv_t div_den;
  div_ctl_t div_ctl;

  bcg_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(div_den), .ctl_o(div_ctl), .quo_o(div_quo));

  logic accept;
  logic [TimeBits-1:0] elapsed;
  logic settled;
  pct_t seg_dp;
  mv_t seg_lo, seg_dv;
  logic [7:0] val, sum;
  pct_t pcur;

  assign accept     = in_valid_i && (st_q == ST_IDLE);
  assign in_stall_o = (st_q != ST_IDLE);
  assign elapsed    = tick_q - chg_tick_q;
  assign settled    = elapsed > {{(TimeBits-16){1'b0}}, settle_q};
  assign seg_lo     = lut_mv(idx_q - 1'b1);
  assign seg_dv     = lut_mv(idx_q) - seg_lo;
  assign seg_dp     = lut_pct(idx_q) - lut_pct(idx_q - 1'b1);
  assign div_num    = PctBits'(seg_dp) * (MvBits+PctBits)'(v_q - seg_lo);
  assign div_den    = seg_dv;

  always_comb begin
    st_d = st_q; mode_d = mode_q; disp_d = disp_q; last_d = last_q;
    lvl_d = lvl_q; tick_d = tick_q; chg_tick_d = chg_tick_q; bat_d = bat_q;
    chg_mv_d = chg_mv_q; off_d = off_q; v_d = v_q; flag_d = flag_q;
    idx_d = idx_q; out_v_d = out_v_q; op_d = op_q; om_d = om_q;
    div_start = 1'b0; val = '0; sum = '0; pcur = lvl_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_OUT;
          unique case (kind_i)
            KIND_TICK: tick_d = tick_q + 1'b1;
            KIND_SAMPLE: bat_d = sample_mv_i;
            KIND_CHARGER: begin
              if (charger_on_i != flag_q) begin
                flag_d = charger_on_i;
                unique case (mode_q)
                  MODE_DIS: if (!flag_q) begin
                    mode_d = MODE_ENTER; chg_tick_d = tick_q; chg_mv_d = bat_q;
                  end
                  MODE_CHG: if (flag_q) begin
                    mode_d = MODE_LEAVE; chg_tick_d = tick_q; chg_mv_d = bat_q;
                    off_d = '0;
                  end
                  MODE_ENTER: mode_d = MODE_LEAVE;
                  default: mode_d = MODE_ENTER;
                endcase
              end
            end
            default: begin
              if (mode_q == MODE_DIS || mode_q == MODE_CHG || settled) begin
                st_d = ST_PREP;
                if (mode_q == MODE_ENTER && off_q == '0)
                  off_d = (bat_q > chg_mv_q) ? bat_q - chg_mv_q : '0;
                else if (mode_q == MODE_LEAVE)
                  off_d = '0;
              end
            end
          endcase
        end
      end
      ST_PREP: begin
        v_d = (bat_q > off_q) ? bat_q - off_q : '0;
        idx_d = IdxBits'(1);
        st_d = ST_SCAN;
        if (v_d < lut_mv('0)) begin
          lvl_d = lut_pct('0); st_d = ST_APPL;
        end else if (v_d >= lut_mv(IdxBits'(TablePoints-1))) begin
          lvl_d = lut_pct(IdxBits'(TablePoints-1)); st_d = ST_APPL;
        end
      end
      ST_SCAN: begin
        if (v_q < lut_mv(idx_q)) begin
          div_start = 1'b1; st_d = ST_DIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_ctl.done) begin
          lvl_d = PctBits'(div_quo) + lut_pct(idx_q - 1'b1);
          st_d = ST_APPL;
        end
      end
      ST_APPL: begin
        st_d = ST_OUT;
        pcur = lvl_q;
        unique case (mode_q)
          MODE_DIS: if (pcur < disp_q) disp_d = pcur;
          MODE_CHG: if (pcur > disp_q) disp_d = pcur;
          MODE_ENTER: begin
            last_d = (last_q == '0) ? pcur : last_q;
            // The step can reach 297 before halving, so it is formed in 9 bits.
            val = (pcur > last_d) ? 8'((9'(pcur - last_d) * 9'd3) >> 1) : 8'd0;
            sum = 8'(disp_q) + val;
            disp_d = (sum > 8'(pcur)) ? pcur : PctBits'(sum);
            last_d = pcur;
            if (disp_d == pcur) begin
              mode_d = MODE_CHG; last_d = '0;
            end
          end
          default: begin
            last_d = (last_q == '0) ? pcur : last_q;
            val = (pcur < last_d) ? 8'((9'(last_d - pcur) * 9'd3) >> 1) : 8'd0;
            sum = 8'(pcur) + val;
            disp_d = (8'(disp_q) < sum) ? pcur : PctBits'(8'(disp_q) - val);
            last_d = pcur;
            if (disp_d == pcur) begin
              mode_d = MODE_DIS; last_d = '0;
            end
          end
        endcase
      end
      default: begin
        // Present the result once; hold it while the receiver stalls.
        if (!out_v_q) begin
          out_v_d = 1'b1; op_d = disp_q; om_d = mode_q;
        end else if (!out_stall_i) begin
          out_v_d = 1'b0; st_d = ST_IDLE;
        end
      end
    endcase
    if (cfg_we_i && cfg_index_i == CFG_START)
      disp_d = (cfg_wdata_i[6:0] > 7'd100) ? 7'd100 : cfg_wdata_i[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; mode_q <= MODE_DIS; disp_q <= 7'd100; last_q <= '0;
      tick_q <= '0; chg_tick_q <= '0; bat_q <= '0; chg_mv_q <= '0;
      off_q <= '0; flag_q <= 1'b0; out_v_q <= 1'b0; settle_q <= 16'd60;
    end else begin
      st_q <= st_d; mode_q <= mode_d; disp_q <= disp_d; last_q <= last_d;
      tick_q <= tick_d; chg_tick_q <= chg_tick_d; bat_q <= bat_d;
      chg_mv_q <= chg_mv_d; off_q <= off_d; flag_q <= flag_d;
      out_v_q <= out_v_d;
      if (cfg_we_i && cfg_index_i == CFG_SETTLE) settle_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d; v_q <= v_d; idx_q <= idx_d; op_q <= op_d; om_q <= om_d;
  end

  assign out_valid_o     = out_v_q;
  assign shown_percent_o = op_q;
  assign gauge_mode_o    = om_q;
endmodule
`default_nettype wire

// ===== design/bcg_checker.sv =====
// Port-level checker for the battery charge gauge, bound to the top level.
// Depends on bcg_pkg and battery_charge_gauge_top.
`default_nettype none
module bcg_port_checker import bcg_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [6:0] shown_percent_o,
  input wire logic [1:0] gauge_mode_o
);
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shown_percent_o <= 7'd100) else $error("percent above 100");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shown_percent_o)
    && $stable(gauge_mode_o)) else $error("stalled result changed");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result pending");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second transaction taken");
endmodule

bind battery_charge_gauge_top bcg_port_checker u_bcg_checker (.*);
`default_nettype wire

// ===== bench/bcg_checker.sv =====
// Checker for the battery charge gauge: watches both channels, predicts each result
// and compares it field by field. Depends on bcg_pkg only.
`timescale 1ns / 100ps
module bcg_checker import bcg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] sample_mv_i,
  input  wire logic        charger_on_i,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [6:0]  shown_percent_o,
  input  wire logic [1:0]  gauge_mode_o,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    pct_t       pct;
    logic [1:0] mode;
  } gauge_res_t;

  gauge_res_t gauge_q[$];

  logic [15:0] settle;
  logic [1:0]  mode;
  pct_t        shown;
  logic [31:0] ticks, chg_tick;
  mv_t         batt, chg_mv, offset;
  pct_t        last_lvl;
  logic        chg_flag;

  localparam int MvTab[11] = '{800, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000,
                               9000, 9500};
  localparam int PctTab[11] = '{0, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100};

  // Interpolates the corrected voltage over the table; a voltage on a table point falls in the segment above it.
  function automatic int charge_level(int b, int off);
    int v;
    v = (b > off) ? b - off : 0;
    if (v < MvTab[0]) return PctTab[0];
    if (v >= MvTab[10]) return PctTab[10];
    for (int i = 1; i < 11; i++)
      if (v < MvTab[i])
        return (v - MvTab[i-1]) * (PctTab[i] - PctTab[i-1]) / (MvTab[i] - MvTab[i-1])
               + PctTab[i-1];
    return PctTab[10];
  endfunction

  task automatic apply_poll();
    int p, v;
    logic [31:0] el;
    el = ticks - chg_tick;
    if (mode == MODE_DIS) begin
      p = charge_level(batt, offset);
      if (p < shown) shown = 7'(p);
    end else if (mode == MODE_CHG) begin
      p = charge_level(batt, offset);
      if (p > shown) shown = 7'(p);
    end else if (el > {16'd0, settle}) begin
      if (mode == MODE_ENTER) begin
        if (offset == 0) offset = (batt > chg_mv) ? batt - chg_mv : 16'd0;
      end else begin
        offset = '0;
      end
      p = charge_level(batt, offset);
      if (last_lvl == 0) last_lvl = 7'(p);
      if (mode == MODE_ENTER) begin
        v = (p > last_lvl) ? (p - last_lvl) * 3 / 2 : 0;
        if (shown + v > p) shown = 7'(p);
        else shown = 7'(shown + v);
      end else begin
        v = (p < last_lvl) ? (last_lvl - p) * 3 / 2 : 0;
        if (shown < p + v) shown = 7'(p);
        else shown = 7'(shown - v);
      end
      last_lvl = 7'(p);
      if (shown == p) begin
        mode = (mode == MODE_ENTER) ? MODE_CHG : MODE_DIS;
        last_lvl = '0;
      end
    end
  endtask

  task automatic apply_charger(logic on);
    if (on != chg_flag) begin
      case (mode)
        MODE_DIS: begin
          mode = MODE_ENTER;
          chg_tick = ticks;
          chg_mv = batt;
        end
        MODE_CHG: begin
          mode = MODE_LEAVE;
          chg_tick = ticks;
          chg_mv = batt;
          offset = '0;
        end
        MODE_ENTER: mode = MODE_LEAVE;
        default: mode = MODE_ENTER;
      endcase
      chg_flag = on;
    end
  endtask

  assign pending = gauge_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    gauge_res_t got, want;
    if (!rst_ni) begin
      settle = 16'd60;
      mode = MODE_DIS;
      shown = 7'd100;
      ticks = 0;
      chg_tick = 0;
      batt = 0;
      chg_mv = 0;
      offset = 0;
      last_lvl = 0;
      chg_flag = 0;
      fail_count = 0;
      gauge_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SETTLE) settle = cfg_wdata_i;
        else shown = (cfg_wdata_i[6:0] > 7'd100) ? 7'd100 : cfg_wdata_i[6:0];
      end
      if (in_valid_i && !in_stall_o) begin
        case (kind_i)
          KIND_TICK: ticks = ticks + 1;
          KIND_SAMPLE: batt = sample_mv_i;
          KIND_CHARGER: apply_charger(charger_on_i);
          default: apply_poll();
        endcase
        gauge_q.push_back('{shown, mode});
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{shown_percent_o, gauge_mode_o};
        if (gauge_q.size() == 0) begin
          $error("result with nothing expected: %0d %0d", got.pct, got.mode);
          fail_count++;
        end else begin
          want = gauge_q.pop_front();
          if (got.pct !== want.pct) begin
            $error("shown_percent expected %0d got %0d", want.pct, got.pct);
            fail_count++;
          end
          if (got.mode !== want.mode) begin
            $error("gauge_mode expected %0d got %0d", want.mode, got.mode);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
// Testbench top for the battery charge gauge: clock, reset, stimulus and verdict.
// Depends on bcg_pkg, battery_charge_gauge_top and bcg_checker.
`timescale 1ns / 100ps
module tb;
  import bcg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = KIND_TICK;
  logic [15:0] sample_mv_i = '0;
  logic        charger_on_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  shown_percent_o;
  logic [1:0]  gauge_mode_o;
  int          fail_count, pending;

  // The sender idles at random except during the calm stretch; the receiver
  // stalls at random and, once, holds off for a long burst.
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  int          quiet_cycles = 0;
  localparam int WatchdogLimit = 20000;

  always #5 clk_i = ~clk_i;

  battery_charge_gauge_top u_top (.*);

  bcg_checker u_chk (.*);

  // The receiver stall. A long hold-off is counted in the stimulus, not here.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (calm) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 19);
  end

  // Watchdog: cycles in which no transaction is accepted on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offers one transaction, with a random gap first, and waits for acceptance.
  task automatic send_item(logic [1:0] k, logic [15:0] mv, logic on);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    sample_mv_i  <= mv;
    charger_on_i <= on;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Register writes happen only while the gauge holds no pending work.
  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A charge cycle: plug in, then mix ticks, polls, samples of a rising voltage
  // and charger transactions, mostly off; then unplug and mix ticks, polls and falling samples.
  task automatic charge_cycle(int settle_max);
    int base, n;
    base = $urandom_range(9800, 600);
    send_item(KIND_SAMPLE, base[15:0], 1'b0);
    send_item(KIND_POLL, 16'h0, 1'b0);
    send_item(KIND_CHARGER, 16'h0, 1'b1);
    n = $urandom_range(settle_max + 4);
    for (int i = 0; i < n + 8; i++) begin
      case ($urandom_range(3))
        0: send_item(KIND_SAMPLE, 16'(base + $urandom_range(1200)), 1'b0);
        1: send_item(KIND_POLL, 16'h0, 1'b0);
        2: send_item(KIND_CHARGER, 16'($urandom), 1'($urandom_range(99) < 8));
        default: send_item(KIND_TICK, 16'($urandom), 1'b0);
      endcase
    end
    send_item(KIND_CHARGER, 16'h0, 1'b0);
    for (int i = 0; i < n + 8; i++) begin
      case ($urandom_range(3))
        0: send_item(KIND_SAMPLE, 16'(base - $urandom_range(500)), 1'b0);
        1: send_item(KIND_POLL, 16'h0, 1'b0);
        default: send_item(KIND_TICK, 16'h0, 1'b0);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: table extremes, exact points, offset learning and clearing.
    write_reg(CFG_SETTLE, 16'd2);
    send_item(KIND_SAMPLE, 16'd0, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    write_reg(CFG_START, 16'd127);
    send_item(KIND_SAMPLE, 16'hFFFF, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    send_item(KIND_SAMPLE, 16'd9500, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    send_item(KIND_SAMPLE, 16'd4567, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    send_item(KIND_CHARGER, 16'd0, 1'b0);
    send_item(KIND_CHARGER, 16'd0, 1'b1);
    send_item(KIND_SAMPLE, 16'd5400, 1'b0);
    for (int i = 0; i < 3; i++) send_item(KIND_TICK, 16'd0, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    send_item(KIND_CHARGER, 16'd0, 1'b0);
    send_item(KIND_SAMPLE, 16'd999, 1'b0);
    for (int i = 0; i < 3; i++) send_item(KIND_TICK, 16'd0, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);
    send_item(KIND_POLL, 16'd0, 1'b0);

    // Random phases over several register settings, extremes included.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(CFG_SETTLE, 16'd0); write_reg(CFG_START, 16'd0); end
        1: begin write_reg(CFG_SETTLE, 16'd5); write_reg(CFG_START, 16'd100); end
        2: begin write_reg(CFG_SETTLE, 16'd60); write_reg(CFG_START, 16'd57); end
        default: begin write_reg(CFG_SETTLE, 16'hFFFF); write_reg(CFG_START, 16'd101); end
      endcase
      calm = (phase == 1);
      for (int j = 0; j < 200; j++) begin
        if (phase < 3 && $urandom_range(99) < 70) begin
          charge_cycle(phase == 2 ? 8 : 6);
          j += 31;
        end else begin
          send_item(2'($urandom), 16'($urandom), 1'($urandom));
        end
      end
      calm = 1'b0;
    end

    // A long receiver hold-off while the sender keeps offering transactions.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_item(2'($urandom), 16'($urandom), 1'($urandom));
    join

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
